// ===== design/ate_pkg.sv =====
// Shared constants, operation codes and control structs of the array table engine.
package ate_pkg;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 4;
    localparam int POS_W       = 7;
    localparam int CAP_W       = 7;
    localparam int ANS_W       = 38;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int DIV_CNT_W   = $clog2(ANS_W + 1);
    localparam int OP_W        = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Operation selected by an input beat.
    localparam logic [FUNC_W-1:0] FN_APPEND = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 4'd2;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 4'd3;
    localparam logic [FUNC_W-1:0] FN_GET    = 4'd4;
    localparam logic [FUNC_W-1:0] FN_SET    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_MAX    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_MIN    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SUM    = 4'd8;
    localparam logic [FUNC_W-1:0] FN_AVG    = 4'd9;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    // Datapath commands issued by the controller.
    localparam logic [OP_W-1:0] DP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] DP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] DP_FAIL      = 5'd2;
    localparam logic [OP_W-1:0] DP_APPEND    = 5'd3;
    localparam logic [OP_W-1:0] DP_SET       = 5'd4;
    localparam logic [OP_W-1:0] DP_RD_POS    = 5'd5;
    localparam logic [OP_W-1:0] DP_CAPTURE   = 5'd6;
    localparam logic [OP_W-1:0] DP_UP_INIT   = 5'd7;
    localparam logic [OP_W-1:0] DP_UP_RD     = 5'd8;
    localparam logic [OP_W-1:0] DP_UP_WR     = 5'd9;
    localparam logic [OP_W-1:0] DP_UP_LAST   = 5'd10;
    localparam logic [OP_W-1:0] DP_DN_RD     = 5'd11;
    localparam logic [OP_W-1:0] DP_DN_WR     = 5'd12;
    localparam logic [OP_W-1:0] DP_DN_LAST   = 5'd13;
    localparam logic [OP_W-1:0] DP_SCAN_INIT = 5'd14;
    localparam logic [OP_W-1:0] DP_SCAN      = 5'd15;
    localparam logic [OP_W-1:0] DP_SCAN_END  = 5'd16;
    localparam logic [OP_W-1:0] DP_DIV       = 5'd17;
    localparam logic [OP_W-1:0] DP_DIV_END   = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] code;
        logic                result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              pos_gt_fill;
        logic              pos_ge_fill;
        logic              up_at_pos;
        logic              dn_last;
        logic              scan_hit;
        logic              scan_done;
        logic              div_done;
    } dp_stat_t;

endpackage

// ===== design/array_table_engine.sv =====
// Top level of the array table engine: controller, datapath and result register.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata: func, value, position
//   m_        out        m_tvalid / m_tready  m_tdata: answer, status
//   cfg_      in         cfg_valid/cfg_ready  cfg_data: capacity
//
// Insert and delete shift the entries above the position; search, max, min, sum and average
// scan the table, and search stops early on a hit. The entry memory, with one read and one
// write a cycle, paces shifts and scans; average adds a one-bit-per-cycle divider over the
// 38-bit sum.
// Reset clears the fill count and sets capacity to 64; memory contents are not cleared.
// A finished result waits in the output register while the next beat is taken in.
module array_table_engine
    import ate_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, from bit 0: func[3:0], value[31:0], position[6:0], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, from bit 0: answer[37:0], status[2:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data
);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [ANS_W-1:0]    dp_answer;
    logic [STATUS_W-1:0] dp_status;
    logic                out_free;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [ANS_W-1:0]    m_answer_reg;
    logic [STATUS_W-1:0] m_status_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    ate_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    ate_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .answer    (dp_answer),
        .status    (dp_status)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.result_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_answer_reg <= dp_answer;
            m_status_reg <= dp_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ANS_W - STATUS_W){1'b0}}, m_status_reg, m_answer_reg};

endmodule

// ===== design/ate_datapath.sv =====
// Datapath of the array table engine: entry memory, fill count, scan and divide units.
module ate_datapath
    import ate_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  cfg_valid,
    input  logic [CAP_W-1:0]      cfg_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [ANS_W-1:0]      answer,
    output logic [STATUS_W-1:0]   status
);

    function automatic logic [ANS_W-1:0] sext_word(input logic [DATA_WIDTH-1:0] w);
        return {{(ANS_W - DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [FUNC_W-1:0]     func_reg,     func_next;
    logic [DATA_WIDTH-1:0] word_reg,     word_next;
    logic [POS_W-1:0]      pos_reg,      pos_next;
    logic [CNT_W-1:0]      fill_reg,     fill_next;
    logic [CAP_W-1:0]      capacity_reg;
    logic [CNT_W-1:0]      ptr_reg,      ptr_next;
    logic                  rvalid_reg,   rvalid_next;
    logic [ANS_W-1:0]      acc_reg,      acc_next;
    logic [DATA_WIDTH-1:0] best_reg,     best_next;
    logic [CNT_W-1:0]      rem_reg,      rem_next;
    logic [ANS_W-1:0]      quo_reg,      quo_next;
    logic                  neg_reg,      neg_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg,  div_cnt_next;
    logic [ANS_W-1:0]      answer_reg,   answer_next;
    logic [STATUS_W-1:0]   status_reg,   status_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;

    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      pos_cnt;
    logic [CNT_W-1:0]      ptr_dec;
    logic [CNT_W-1:0]      ptr_inc;
    logic                  scan_first;
    logic [ANS_W-1:0]      acc_abs;
    logic [CNT_W:0]        div_trial;
    logic [CNT_W:0]        div_diff;
    logic                  div_fits;

    assign limit   = (CNT_W'(capacity_reg) < CNT_W'(DEPTH)) ? CNT_W'(capacity_reg)
                                                             : CNT_W'(DEPTH);
    assign pos_cnt = CNT_W'(pos_reg);
    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign ptr_inc = ptr_reg + CNT_W'(1);

    // The word in rd_data_reg belongs to index ptr - 1 while a scan runs.
    assign scan_first = (ptr_reg == CNT_W'(1));

    assign acc_abs   = acc_reg[ANS_W-1] ? (~acc_reg + ANS_W'(1)) : acc_reg;
    assign div_trial = {rem_reg, quo_reg[ANS_W-1]};
    assign div_diff  = div_trial - {1'b0, fill_reg};
    assign div_fits  = (div_trial >= {1'b0, fill_reg});

    always_comb begin
        stat.func        = func_reg;
        stat.full        = (fill_reg >= limit);
        stat.empty       = (fill_reg == '0);
        stat.pos_gt_fill = (pos_cnt > fill_reg);
        stat.pos_ge_fill = (pos_cnt >= fill_reg);
        stat.up_at_pos   = (ptr_reg == pos_cnt);
        stat.dn_last     = (ptr_inc >= fill_reg);
        stat.scan_hit    = rvalid_reg && (func_reg == FN_SEARCH) && (rd_data_reg == word_reg);
        stat.scan_done   = !rvalid_reg && (ptr_reg >= fill_reg);
        stat.div_done    = (div_cnt_reg == '0);
    end

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = fill_reg[ADDR_W-1:0];
        mem_wdata = word_reg;
        mem_raddr = ptr_reg[ADDR_W-1:0];
        case (cmd.op)
            DP_APPEND: begin
                mem_we = 1'b1;
            end
            DP_SET, DP_UP_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[ADDR_W-1:0];
            end
            DP_UP_WR, DP_DN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[ADDR_W-1:0];
                mem_wdata = rd_data_reg;
            end
            DP_RD_POS: begin
                mem_raddr = pos_reg[ADDR_W-1:0];
            end
            DP_UP_RD: begin
                mem_raddr = ptr_dec[ADDR_W-1:0];
            end
            DP_DN_RD: begin
                mem_raddr = ptr_inc[ADDR_W-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        func_next    = func_reg;
        word_next    = word_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        rvalid_next  = rvalid_reg;
        acc_next     = acc_reg;
        best_next    = best_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        div_cnt_next = div_cnt_reg;
        answer_next  = answer_reg;
        status_next  = status_reg;
        case (cmd.op)
            DP_LOAD: begin
                func_next   = s_tdata[FUNC_W-1:0];
                word_next   = s_tdata[FUNC_W +: DATA_WIDTH];
                pos_next    = s_tdata[FUNC_W + 32 +: POS_W];
                answer_next = '0;
                status_next = ST_OK;
            end
            DP_FAIL: begin
                answer_next = '0;
                status_next = cmd.code;
            end
            DP_APPEND, DP_UP_LAST: begin
                fill_next = fill_reg + CNT_W'(1);
            end
            DP_CAPTURE: begin
                answer_next = sext_word(rd_data_reg);
                ptr_next    = pos_cnt;
            end
            DP_UP_INIT: begin
                ptr_next = fill_reg;
            end
            DP_UP_WR: begin
                ptr_next = ptr_dec;
            end
            DP_DN_WR: begin
                ptr_next = ptr_inc;
            end
            DP_DN_LAST: begin
                fill_next = fill_reg - CNT_W'(1);
            end
            DP_SCAN_INIT: begin
                ptr_next    = '0;
                rvalid_next = 1'b0;
                acc_next    = '0;
                if (func_reg == FN_SEARCH) begin
                    status_next = ST_MISS;
                end
            end
            DP_SCAN: begin
                if (ptr_reg < fill_reg) begin
                    ptr_next    = ptr_inc;
                    rvalid_next = 1'b1;
                end else begin
                    rvalid_next = 1'b0;
                end
                if (rvalid_reg) begin
                    acc_next = acc_reg + sext_word(rd_data_reg);
                    if (scan_first
                        || ((func_reg == FN_MAX)
                            && ($signed(rd_data_reg) > $signed(best_reg)))
                        || ((func_reg == FN_MIN)
                            && ($signed(rd_data_reg) < $signed(best_reg)))) begin
                        best_next = rd_data_reg;
                    end
                end
                if (stat.scan_hit) begin
                    answer_next = ANS_W'(ptr_dec);
                    status_next = ST_OK;
                end
            end
            DP_SCAN_END: begin
                if ((func_reg == FN_MAX) || (func_reg == FN_MIN)) begin
                    answer_next = sext_word(best_reg);
                end else if (func_reg == FN_SUM) begin
                    answer_next = acc_reg;
                end
                // Prepare the divider on the magnitude of the sum.
                rem_next     = '0;
                quo_next     = acc_abs;
                neg_next     = acc_reg[ANS_W-1];
                div_cnt_next = DIV_CNT_W'(ANS_W);
            end
            DP_DIV: begin
                rem_next     = div_fits ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
                quo_next     = {quo_reg[ANS_W-2:0], div_fits};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            end
            DP_DIV_END: begin
                answer_next = neg_reg ? (~quo_reg + ANS_W'(1)) : quo_reg;
            end
            default: begin
                func_next = func_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            capacity_reg <= CAP_RESET;
            rvalid_reg   <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            rvalid_reg <= rvalid_next;
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        word_reg    <= word_next;
        pos_reg     <= pos_next;
        ptr_reg     <= ptr_next;
        acc_reg     <= acc_next;
        best_reg    <= best_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        div_cnt_reg <= div_cnt_next;
        answer_reg  <= answer_next;
        status_reg  <= status_next;
    end

    assign answer = answer_reg;
    assign status = status_reg;

endmodule

// ===== design/ate_ctrl.sv =====
// Controller state machine of the array table engine.
module ate_ctrl
    import ate_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int STATE_W = 4;

    localparam logic [STATE_W-1:0] S_IDLE    = 4'd0;
    localparam logic [STATE_W-1:0] S_DECODE  = 4'd1;
    localparam logic [STATE_W-1:0] S_CAPTURE = 4'd2;
    localparam logic [STATE_W-1:0] S_UP_RD   = 4'd3;
    localparam logic [STATE_W-1:0] S_UP_WR   = 4'd4;
    localparam logic [STATE_W-1:0] S_DN_RD   = 4'd5;
    localparam logic [STATE_W-1:0] S_DN_WR   = 4'd6;
    localparam logic [STATE_W-1:0] S_SCAN    = 4'd7;
    localparam logic [STATE_W-1:0] S_DIV     = 4'd8;
    localparam logic [STATE_W-1:0] S_DONE    = 4'd9;

    logic [STATE_W-1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd.op          = DP_NOP;
        cmd.code        = ST_OK;
        cmd.result_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (stat.func)
                    FN_APPEND: begin
                        if (stat.full) begin
                            cmd.op   = DP_FAIL;
                            cmd.code = ST_FULL;
                        end else begin
                            cmd.op = DP_APPEND;
                        end
                    end
                    FN_INSERT: begin
                        // Range is checked before fullness.
                        if (stat.pos_gt_fill) begin
                            cmd.op   = DP_FAIL;
                            cmd.code = ST_RANGE;
                        end else if (stat.full) begin
                            cmd.op   = DP_FAIL;
                            cmd.code = ST_FULL;
                        end else begin
                            cmd.op     = DP_UP_INIT;
                            state_next = S_UP_RD;
                        end
                    end
                    FN_DELETE, FN_GET: begin
                        if (stat.pos_ge_fill) begin
                            cmd.op   = DP_FAIL;
                            cmd.code = ST_RANGE;
                        end else begin
                            cmd.op     = DP_RD_POS;
                            state_next = S_CAPTURE;
                        end
                    end
                    FN_SET: begin
                        if (stat.pos_ge_fill) begin
                            cmd.op   = DP_FAIL;
                            cmd.code = ST_RANGE;
                        end else begin
                            cmd.op = DP_SET;
                        end
                    end
                    FN_SEARCH: begin
                        cmd.op     = DP_SCAN_INIT;
                        state_next = S_SCAN;
                    end
                    FN_MAX, FN_MIN, FN_SUM, FN_AVG: begin
                        if (stat.empty) begin
                            cmd.op   = DP_FAIL;
                            cmd.code = ST_EMPTY;
                        end else begin
                            cmd.op     = DP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.op = DP_NOP;
                    end
                endcase
            end
            S_CAPTURE: begin
                cmd.op     = DP_CAPTURE;
                state_next = (stat.func == FN_DELETE) ? S_DN_RD : S_DONE;
            end
            S_UP_RD: begin
                if (stat.up_at_pos) begin
                    cmd.op     = DP_UP_LAST;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_UP_RD;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                cmd.op     = DP_UP_WR;
                state_next = S_UP_RD;
            end
            S_DN_RD: begin
                if (stat.dn_last) begin
                    cmd.op     = DP_DN_LAST;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_DN_RD;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                cmd.op     = DP_DN_WR;
                state_next = S_DN_RD;
            end
            S_SCAN: begin
                if (stat.scan_hit) begin
                    cmd.op     = DP_SCAN;
                    state_next = S_DONE;
                end else if (stat.scan_done) begin
                    cmd.op     = DP_SCAN_END;
                    state_next = (stat.func == FN_AVG) ? S_DIV : S_DONE;
                end else begin
                    cmd.op = DP_SCAN;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.op     = DP_DIV_END;
                    state_next = S_DONE;
                end else begin
                    cmd.op = DP_DIV;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
